>>> src/modbus_rtu_response_parser_assert.svh
// Assertion macros shared by the Modbus RTU response parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MODBUS_RTU_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks that a condition holds at every clock edge out of reset.
`define MRP_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mrp assertion failed");
// Checks that a consequent holds in the same cycle as its antecedent.
`define MRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrp implication failed");
// Checks that a consequent holds in the cycle after its antecedent.
`define MRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrp next-cycle check failed");
`else
`define MRP_ASSERT(lbl, clk, rst_n, expr)
`define MRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/mrp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the response parser.
// No dependencies; the APB config, the parser core and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package mrp_pkg;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [8:0]  POS_MAX         = 9'd511;
    localparam int unsigned EXC_BIT         = 7;
    localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd252;
    localparam logic [7:0]  WRITE_COUNT     = 8'd4;

    // APB byte address of the one configuration register
    localparam logic [1:0]  ADDR_MAX_PAYLOAD = 2'd0;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_CRC   = 3'd2,
        ST_LEN   = 3'd3,
        ST_UNSUP = 3'd4
    } t_status;

    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

    typedef struct packed {
        logic       last;
        logic [2:0] status;
        logic [7:0] unit_addr;
        logic [7:0] fn_code;
        logic       exc_flag;
        logic [7:0] exc_code;
        logic [7:0] pay_len;
        logic [7:0] data_index;
        logic [7:0] data_value;
        logic [15:0] frame_crc;
    } t_result;

    // Reflected CRC-16 update of one byte, eight shift steps.
    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    function automatic logic is_read_fc(input logic [7:0] f);
        return (f >= FC_READ_COILS) && (f <= FC_READ_HOLDING);
    endfunction

    function automatic logic is_write_fc(input logic [7:0] f);
        return (f == FC_WRITE_COIL) || (f == FC_WRITE_REG) ||
               (f == FC_WRITE_COILS) || (f == FC_WRITE_REGS);
    endfunction

endpackage

`default_nettype wire

>>> src/mrp_stream_if.sv
// Valid/ready stream interfaces for received bytes and parser results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mrp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrp_res_if;
    logic        valid;
    logic        ready;
    logic        last;
    logic [2:0]  status;
    logic [7:0]  unit_addr;
    logic [7:0]  fn_code;
    logic        exc_flag;
    logic [7:0]  exc_code;
    logic [7:0]  pay_len;
    logic [7:0]  data_index;
    logic [7:0]  data_value;
    logic [15:0] frame_crc;

    modport source (output valid, output last, output status, output unit_addr,
                    output fn_code, output exc_flag, output exc_code,
                    output pay_len, output data_index, output data_value,
                    output frame_crc, input ready);
    modport sink   (input valid, input last, input status, input unit_addr,
                    input fn_code, input exc_flag, input exc_code,
                    input pay_len, input data_index, input data_value,
                    input frame_crc, output ready);
endinterface

`default_nettype wire

>>> src/mrp_apb_cfg.sv
// APB configuration register block holding the read payload limit.
// Depends on mrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrp_apb_cfg
    import mrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  o_max_payload
);

    logic [7:0] r_max_payload;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready && (paddr == ADDR_MAX_PAYLOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (wr_hit) begin
            r_max_payload <= pwdata[7:0];
        end
    end

    assign prdata        = (paddr == ADDR_MAX_PAYLOAD) ? {24'h000000, r_max_payload} : 32'h0;
    assign o_max_payload = r_max_payload;

endmodule

`default_nettype wire

>>> src/mrp_parse.sv
// Frame state, streaming CRC, frame checks and the result register.
// Depends on mrp_pkg, mrp_stream_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_rtu_response_parser_assert.svh"

module mrp_parse
    import mrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_frame_end,
    output logic            o_ready,
    input  wire logic [7:0] i_max_payload,
    mrp_res_if.source       o_res
);

    logic [8:0]  r_pos;
    logic [15:0] r_crc;
    logic [7:0]  r_d0;
    logic [7:0]  r_d1;
    logic [7:0]  r_dev;
    logic [7:0]  r_fn;
    logic [7:0]  r_third;
    logic        r_out_valid;
    t_result     r_res;

    logic        fire;
    logic [15:0] n_crc;
    logic [7:0]  dev_eff;
    logic [7:0]  fn_eff;
    logic [7:0]  third_eff;
    logic [9:0]  len;
    logic [15:0] rcrc;
    logic [8:0]  pos_m3;
    logic [8:0]  pos_m2;
    logic        n_emit;
    t_result     n_res;

    assign o_ready = !r_out_valid || o_res.ready;
    assign fire    = i_valid && o_ready;

    always_comb begin
        n_crc     = (r_pos >= 9'd2) ? crc_feed(r_crc, r_d1) : r_crc;
        dev_eff   = (r_pos == 9'd0) ? i_rx_byte : r_dev;
        fn_eff    = (r_pos == 9'd1) ? i_rx_byte : r_fn;
        third_eff = (r_pos == 9'd2) ? i_rx_byte : r_third;
        len       = {1'b0, r_pos} + 10'd1;
        rcrc      = {i_rx_byte, r_d0};
        pos_m3    = r_pos - 9'd3;
        pos_m2    = r_pos - 9'd2;
        n_emit    = 1'b0;
        n_res     = '0;

        if (i_frame_end) begin
            n_emit    = 1'b1;
            n_res.last = 1'b1;
            if (r_pos < 9'd2) begin
                n_res.status = ST_SHORT;
            end else if (rcrc != n_crc) begin
                n_res.status = ST_CRC;
            end else begin
                n_res.unit_addr = dev_eff;
                n_res.fn_code   = fn_eff;
                if (fn_eff[EXC_BIT]) begin
                    n_res.exc_flag  = 1'b1;
                    n_res.exc_code  = third_eff;
                    n_res.frame_crc = rcrc;
                end else if (is_read_fc(fn_eff)) begin
                    if ((third_eff > i_max_payload) ||
                        (len < (10'd5 + {2'b00, third_eff}))) begin
                        n_res.status = ST_LEN;
                    end else begin
                        n_res.pay_len   = third_eff;
                        n_res.frame_crc = rcrc;
                    end
                end else if (is_write_fc(fn_eff)) begin
                    if (len < 10'd6) begin
                        n_res.status = ST_LEN;
                    end else begin
                        n_res.pay_len   = WRITE_COUNT;
                        n_res.frame_crc = rcrc;
                    end
                end else begin
                    n_res.status = ST_UNSUP;
                end
            end
        end else begin
            // Payload bytes: the declared count for reads, four bytes for writes.
            if ((r_pos >= 9'd3) && is_read_fc(fn_eff) && (r_third <= i_max_payload) &&
                (pos_m3 < {1'b0, r_third})) begin
                n_emit           = 1'b1;
                n_res.pay_len    = r_third;
                n_res.data_index = pos_m3[7:0];
            end else if ((r_pos >= 9'd2) && (r_pos <= 9'd5) && is_write_fc(fn_eff)) begin
                n_emit           = 1'b1;
                n_res.pay_len    = WRITE_COUNT;
                n_res.data_index = pos_m2[7:0];
            end
            if (n_emit) begin
                n_res.unit_addr  = dev_eff;
                n_res.fn_code    = fn_eff;
                n_res.data_value = i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 9'd0;
            r_crc       <= CRC_INIT;
            r_d0        <= 8'h00;
            r_d1        <= 8'h00;
            r_dev       <= 8'h00;
            r_fn        <= 8'h00;
            r_third     <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= n_emit;
                if (i_frame_end) begin
                    r_pos   <= 9'd0;
                    r_crc   <= CRC_INIT;
                    r_d0    <= 8'h00;
                    r_d1    <= 8'h00;
                    r_dev   <= 8'h00;
                    r_fn    <= 8'h00;
                    r_third <= 8'h00;
                end else begin
                    r_crc   <= n_crc;
                    r_dev   <= dev_eff;
                    r_fn    <= fn_eff;
                    r_third <= third_eff;
                    r_d1    <= r_d0;
                    r_d0    <= i_rx_byte;
                    if (r_pos != POS_MAX) begin
                        r_pos <= r_pos + 9'd1;
                    end
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_emit) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.last       = r_res.last;
    assign o_res.status     = r_res.status;
    assign o_res.unit_addr  = r_res.unit_addr;
    assign o_res.fn_code    = r_res.fn_code;
    assign o_res.exc_flag   = r_res.exc_flag;
    assign o_res.exc_code   = r_res.exc_code;
    assign o_res.pay_len    = r_res.pay_len;
    assign o_res.data_index = r_res.data_index;
    assign o_res.data_value = r_res.data_value;
    assign o_res.frame_crc  = r_res.frame_crc;

    // A frame end always restarts the position count.
    `MRP_ASSERT_NEXT(a_end_clears_pos, i_clk, i_rst_n, fire && i_frame_end, r_pos == 9'd0)
    // The CRC starts accumulating only once the third byte has been taken.
    `MRP_ASSERT_IMP(a_crc_idle_early, i_clk, i_rst_n, r_pos <= 9'd2, r_crc == CRC_INIT)
    // Payload words always carry an ok status.
    `MRP_ASSERT_IMP(a_payload_ok, i_clk, i_rst_n, r_out_valid && !r_res.last,
                    r_res.status == ST_OK)
    // The exception flag only appears with bit 7 of the function code set.
    `MRP_ASSERT_IMP(a_exc_bit, i_clk, i_rst_n, r_out_valid && r_res.exc_flag,
                    r_res.fn_code[EXC_BIT])

endmodule

`default_nettype wire

>>> src/modbus_rtu_response_parser.sv
// Top level of the Modbus RTU response parser: input register, APB config, parser core.
// Depends on mrp_pkg, mrp_stream_if, mrp_apb_cfg and mrp_parse.
//
// Usage: the receive channel i_rx carries one frame byte per word, in wire order,
// with frame_end set on the last byte of each response frame. The result channel
// o_res returns one word for every payload byte of a supported read or write
// response (last low), and one status word per frame (last high) that reports ok,
// too short, CRC error, bad length or unsupported function. Payload words are sent
// as the bytes arrive; a consumer keeps them only if the closing status is ok.
// Bytes pass the input, then the result register. The block takes one byte per cycle
// unless the output stalls: the CRC update is an eight-step XOR network on the byte
// two positions back, so nothing loops across cycles. A byte that yields no result
// simply leaves no output word. The APB port holds max_payload at byte address 0
// (reset value 252); the user must write it only while no frame is in flight; the block
// does not enforce it. Reset (synchronous, active low) clears the frame state, the CRC
// to 0xFFFF and both valid flags. When the receiver stalls, the result register holds
// its word and the input register still takes one more byte before ready drops.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_parser
    import mrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mrp_rx_if.sink           i_rx,
    mrp_res_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Input register: decouples the receive handshake from the parser core.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_end;
    logic       core_ready;
    logic [7:0] max_payload;

    // The input register is free when empty or when the core takes its byte now.
    assign i_rx.ready = !r_s1_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_s1_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_s1_byte <= i_rx.rx_byte;
            r_s1_end  <= i_rx.frame_end;
        end
    end

    mrp_apb_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_payload (max_payload)
    );

    // The core does all frame bookkeeping and owns the result register.
    mrp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_s1_valid),
        .i_rx_byte     (r_s1_byte),
        .i_frame_end   (r_s1_end),
        .o_ready       (core_ready),
        .i_max_payload (max_payload),
        .o_res         (o_res)
    );

endmodule

`default_nettype wire
